FILE: rtl/core/dhsc_pkg.sv
// Shared types, constants and the header CRC helper for the disk header seek controller.
// Used by every module under rtl/core; depends on nothing else.
package dhsc_pkg;

    localparam int TRACK_COUNT_DEF = 512;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_IDX_BAD_LIMIT   = 1'b0;
    localparam logic REG_IDX_RETRY_LIMIT = 1'b1;

    localparam logic [5:0] BAD_LIMIT_RST   = 6'd40;
    localparam logic [4:0] RETRY_LIMIT_RST = 5'd15;

    localparam logic [15:0] SEEK_CMD_BASE   = 16'b0010000000000000;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [8:0]  NUDGE_CYL_LIMIT = 9'd255;
    localparam logic [4:0]  SEEKS_FULL      = 5'b11111;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_SEEK    = 2'd1,
        KIND_ARRIVED = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_INVALID_REQ = 2'd0,
        ERR_BAD_CRC     = 2'd1,
        ERR_SEEK_FAIL   = 2'd2
    } err_t;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_HEADER  = 1'b1
    } op_t;

    typedef struct packed {
        logic [5:0] bad_header_limit;
        logic [4:0] seek_retry_limit;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  head;
        logic [9:0]  track;
        logic [15:0] header_word;
        logic [15:0] reserved_word;
        logic [15:0] crc_word;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] command_word;
        logic [5:0]  sector;
        err_t        error_code;
    } result_t;

    // CRC-16/ARC (init 0) contribution of one message bit; the message is
    // {reserved_word, header_word}, shifted in from bit 0. Constant-folded per bit.
    function automatic logic [15:0] crc_column(input int idx);
        logic [15:0] crc;
        logic        fb;
        crc = '0;
        for (int b = 0; b < 32; b++) begin
            fb  = crc[0] ^ (b == idx);
            crc = {1'b0, crc[15:1]};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/disk_header_seek_controller.sv
// An accepted transfer passes through the input register, then the result register on m_*,
// with the CRC check and seek decision in between.
// Throughput: one transfer per cycle unless m_tready stalls; a taken result frees its register.
// Reset: aresetn is synchronous, active low; it ends any request, clears the remembered
// position and counters, and sets the bad header limit to 40 and the seek retry limit to 15.
module disk_header_seek_controller
    import dhsc_pkg::*;
#(
    parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // head[1:0], track[11:2], header_word[27:12], reserved_word[43:28], crc_word[59:44], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // command_word[15:0], sector[21:16], error_code[23:22]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]            m_tuser
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    crc_ok;

    dhsc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item.op            = op_t'(s_tuser);
    assign in_item.head          = s_tdata[1:0];
    assign in_item.track         = s_tdata[11:2];
    assign in_item.header_word   = s_tdata[27:12];
    assign in_item.reserved_word = s_tdata[43:28];
    assign in_item.crc_word      = s_tdata[59:44];

    // Move the held item into the result register whenever that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_tready);

    dhsc_crc u_crc (
        .header_word   (in_item_reg.header_word),
        .reserved_word (in_item_reg.reserved_word),
        .crc_word      (in_item_reg.crc_word),
        .crc_ok        (crc_ok)
    );

    dhsc_core #(
        .TRACK_COUNT (TRACK_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .crc_ok  (crc_ok),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_item_reg <= in_item;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'(out_res_reg.error_code), out_res_reg.sector,
                       out_res_reg.command_word};
    assign m_tuser  = 2'(out_res_reg.kind);

endmodule

FILE: rtl/core/dhsc_cfg.sv
// APB register file for the two retry limits of the seek controller.
// Depends on dhsc_pkg.
module dhsc_cfg
    import dhsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_IDX_BAD_LIMIT: begin
                    cfg_next.bad_header_limit = pwdata[5:0];
                end
                REG_IDX_RETRY_LIMIT: begin
                    cfg_next.seek_retry_limit = pwdata[4:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_BAD_LIMIT: begin
                prdata = {{(APB_DATA_W-6){1'b0}}, cfg_reg.bad_header_limit};
            end
            REG_IDX_RETRY_LIMIT: begin
                prdata = {{(APB_DATA_W-5){1'b0}}, cfg_reg.seek_retry_limit};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bad_header_limit <= BAD_LIMIT_RST;
            cfg_reg.seek_retry_limit <= RETRY_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/dhsc_crc.sv
// Header CRC check: CRC-16/ARC over header word then reserved word, low byte first.
// Depends on dhsc_pkg (crc_column).
module dhsc_crc
    import dhsc_pkg::*;
(
    input  logic [15:0] header_word,
    input  logic [15:0] reserved_word,
    input  logic [15:0] crc_word,
    output logic        crc_ok
);

    logic [31:0] msg;
    logic [15:0] crc;

    assign msg = {reserved_word, header_word};

    // CRC with zero init is linear: XOR the column of every set message bit
    always_comb begin
        crc = '0;
        for (int i = 0; i < 32; i++) begin
            if (msg[i]) begin
                crc = crc ^ crc_column(i);
            end
        end
    end

    assign crc_ok = (crc == crc_word);

endmodule

FILE: rtl/core/dhsc_core.sv
// Request state and per-header decision logic: range check, CRC budget, arrival, seek command.
// Depends on dhsc_pkg; fed by dhsc_crc and dhsc_cfg.
module dhsc_core
    import dhsc_pkg::*;
#(
    parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  logic    crc_ok,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [9:0] TrackLimit = 10'(TRACK_COUNT);

    logic       busy_reg,         busy_next;
    logic       goal_head_reg,    goal_head_next;
    logic [8:0] goal_track_reg,   goal_track_next;
    logic       skip_compare_reg, skip_compare_next;
    logic       known_head_reg,   known_head_next;
    logic [8:0] known_track_reg,  known_track_next;
    logic [4:0] seeks_issued_reg, seeks_issued_next;
    logic [5:0] bad_headers_reg,  bad_headers_next;
    logic [8:0] seen_cyl_reg,     seen_cyl_next;
    logic       seen_head_reg,    seen_head_next;
    logic       seen_valid_reg,   seen_valid_next;

    logic [8:0]  cyl;
    logic        hh;
    logic [5:0]  sec;
    logic        stuck;
    logic        inward;
    logic [8:0]  seek_dist;
    logic [15:0] cmd_base;
    logic [15:0] cmd;
    logic [6:0]  bad_inc;
    logic        req_invalid;
    logic        seek_fail;

    assign sec       = item.header_word[5:0];
    assign hh        = item.header_word[6];
    assign cyl       = item.header_word[15:7];
    assign stuck     = seen_valid_reg && (seen_cyl_reg == cyl) && (seen_head_reg == hh);
    assign inward    = goal_track_reg > cyl;
    assign seek_dist = inward ? (goal_track_reg - cyl) : (cyl - goal_track_reg);

    assign cmd_base = SEEK_CMD_BASE | {6'd0, inward, seek_dist}
                    | {5'd0, goal_head_reg, 10'd0};

    // Nudge a drive that has not moved since the last good header, when the low two bits of the seek count are set
    always_comb begin
        cmd = cmd_base;
        if ((seeks_issued_reg[1:0] == 2'b11) && stuck) begin
            if (cyl < NUDGE_CYL_LIMIT) begin
                cmd = cmd_base + 16'd1;
            end else begin
                cmd = cmd_base - 16'd1;
            end
        end
    end

    assign bad_inc     = {1'b0, bad_headers_reg} + 7'd1;
    assign req_invalid = item.head[1] || (item.track >= TrackLimit);
    assign seek_fail   = (seeks_issued_reg > cfg.seek_retry_limit)
                      || (seeks_issued_reg == SEEKS_FULL);

    always_comb begin
        busy_next         = busy_reg;
        goal_head_next    = goal_head_reg;
        goal_track_next   = goal_track_reg;
        skip_compare_next = skip_compare_reg;
        known_head_next   = known_head_reg;
        known_track_next  = known_track_reg;
        seeks_issued_next = seeks_issued_reg;
        bad_headers_next  = bad_headers_reg;
        seen_cyl_next     = seen_cyl_reg;
        seen_head_next    = seen_head_reg;
        seen_valid_next   = seen_valid_reg;
        res.kind          = KIND_NONE;
        res.command_word  = '0;
        res.sector        = '0;
        res.error_code    = ERR_INVALID_REQ;

        if (step) begin
            if (item.op == OP_REQUEST) begin
                if (req_invalid) begin
                    busy_next = 1'b0;
                    res.kind  = KIND_ERROR;
                end else begin
                    busy_next         = 1'b1;
                    goal_head_next    = item.head[0];
                    goal_track_next   = item.track[8:0];
                    skip_compare_next = (known_head_reg == item.head[0])
                                     && (known_track_reg == item.track[8:0]);
                    seeks_issued_next = '0;
                    bad_headers_next  = '0;
                    seen_valid_next   = 1'b0;
                    seen_cyl_next     = '0;
                    seen_head_next    = 1'b0;
                end
            end else if (busy_reg) begin
                priority if (!crc_ok) begin
                    if (bad_inc > {1'b0, cfg.bad_header_limit}) begin
                        busy_next      = 1'b0;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_CRC;
                    end else begin
                        bad_headers_next = bad_inc[5:0];
                    end
                end else if (skip_compare_reg) begin
                    busy_next  = 1'b0;
                    res.kind   = KIND_ARRIVED;
                    res.sector = sec;
                end else begin
                    seen_cyl_next   = cyl;
                    seen_head_next  = hh;
                    seen_valid_next = 1'b1;
                    priority if ((cyl == goal_track_reg) && (hh == goal_head_reg)) begin
                        known_head_next  = goal_head_reg;
                        known_track_next = goal_track_reg;
                        busy_next        = 1'b0;
                        res.kind         = KIND_ARRIVED;
                        res.sector       = sec;
                    end else if (seek_fail) begin
                        busy_next      = 1'b0;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SEEK_FAIL;
                    end else begin
                        seeks_issued_next = seeks_issued_reg + 5'd1;
                        res.kind          = KIND_SEEK;
                        res.command_word  = cmd;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            goal_head_reg    <= 1'b0;
            goal_track_reg   <= '0;
            skip_compare_reg <= 1'b0;
            known_head_reg   <= 1'b0;
            known_track_reg  <= '0;
            seeks_issued_reg <= '0;
            bad_headers_reg  <= '0;
            seen_cyl_reg     <= '0;
            seen_head_reg    <= 1'b0;
            seen_valid_reg   <= 1'b0;
        end else begin
            busy_reg         <= busy_next;
            goal_head_reg    <= goal_head_next;
            goal_track_reg   <= goal_track_next;
            skip_compare_reg <= skip_compare_next;
            known_head_reg   <= known_head_next;
            known_track_reg  <= known_track_next;
            seeks_issued_reg <= seeks_issued_next;
            bad_headers_reg  <= bad_headers_next;
            seen_cyl_reg     <= seen_cyl_next;
            seen_head_reg    <= seen_head_next;
            seen_valid_reg   <= seen_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_error_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (res.kind == KIND_ERROR)) |=> !busy_reg)
        else $error("request still active after an error result");

    a_seek_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (res.kind == KIND_SEEK)) |=>
        (seeks_issued_reg == $past(seeks_issued_reg) + 5'd1))
        else $error("seek command issued without counting it");

    a_arrival_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (res.kind == KIND_ARRIVED)) |=>
        ((known_head_reg == goal_head_reg) && (known_track_reg == goal_track_reg)))
        else $error("arrival does not leave the position known");

    a_idle_header_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (item.op == OP_HEADER) && !busy_reg) |=>
        (!busy_reg && $stable(seeks_issued_reg) && $stable(bad_headers_reg)))
        else $error("header while idle changed request state");
`endif

endmodule

FILE: tb/disk_header_seek_controller_check.sv
`timescale 1ns / 100ps
// Checker for the disk header seek controller: watches the APB port and both streams,
// predicts each result from its own copy of the seek state, and compares field by field.
// Depends on dhsc_pkg for the item, result and code types.
module disk_header_seek_controller_check
    import dhsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // head[1:0], track[11:2], header_word[27:12], reserved_word[43:28], crc_word[59:44]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // command_word[15:0], sector[21:16], error_code[23:22]
    input  logic [M_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    input  logic [1:0]            m_tuser,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [15:0] INWARD_BIT = 16'h0200;

    cfg_t       cfg;
    logic       active;
    logic       goal_hd;
    logic [8:0] goal_cyl;
    logic       skip;
    logic       known_hd;
    logic [8:0] known_cyl;
    logic [4:0] seek_cnt;
    logic [5:0] bad_cnt;
    logic [8:0] last_cyl;
    logic       last_hd;
    logic       last_ok;

    result_t outcome_q[$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [15:0] header_crc(input logic [15:0] hw, input logic [15:0] rw);
        logic [15:0] crc;
        logic [31:0] msg;
        crc = '0;
        msg = {rw, hw};
        for (int i = 0; i < 4; i++) begin
            crc = crc ^ {8'h00, msg[8*i +: 8]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    task automatic advance_seek(input item_t it, output result_t res);
        logic [8:0]  cyl;
        logic        hb;
        logic [6:0]  bad_next;
        logic [15:0] cmd;
        logic        stuck;
        res = '0;
        if (it.op == OP_REQUEST) begin
            if (it.head > 2'd1 || it.track >= TRACK_COUNT_DEF) begin
                active = 1'b0;
                res.kind = KIND_ERROR;
                res.error_code = ERR_INVALID_REQ;
            end else begin
                active = 1'b1;
                goal_hd = it.head[0];
                goal_cyl = it.track[8:0];
                skip = (known_hd == goal_hd) && (known_cyl == goal_cyl);
                seek_cnt = '0;
                bad_cnt = '0;
                last_ok = 1'b0;
                last_cyl = '0;
                last_hd = 1'b0;
            end
        end else if (active) begin
            if (header_crc(it.header_word, it.reserved_word) != it.crc_word) begin
                bad_next = {1'b0, bad_cnt} + 7'd1;
                if (bad_next > {1'b0, cfg.bad_header_limit}) begin
                    active = 1'b0;
                    res.kind = KIND_ERROR;
                    res.error_code = ERR_BAD_CRC;
                end else begin
                    bad_cnt = bad_next[5:0];
                end
            end else if (skip) begin
                // already on the requested track: first good header ends the request
                active = 1'b0;
                res.kind = KIND_ARRIVED;
                res.sector = it.header_word[5:0];
            end else begin
                cyl = it.header_word[15:7];
                hb = it.header_word[6];
                stuck = last_ok && (last_cyl == cyl) && (last_hd == hb);
                last_cyl = cyl;
                last_hd = hb;
                last_ok = 1'b1;
                if (cyl == goal_cyl && hb == goal_hd) begin
                    known_hd = goal_hd;
                    known_cyl = goal_cyl;
                    active = 1'b0;
                    res.kind = KIND_ARRIVED;
                    res.sector = it.header_word[5:0];
                end else begin
                    if (goal_cyl > cyl) begin
                        cmd = SEEK_CMD_BASE | {7'd0, goal_cyl - cyl} | INWARD_BIT;
                    end else begin
                        cmd = SEEK_CMD_BASE | {7'd0, cyl - goal_cyl};
                    end
                    cmd = cmd | ({15'd0, goal_hd} << 10);
                    // nudge a drive that did not move since the last good header
                    if (seek_cnt[1:0] == 2'b11 && stuck) begin
                        cmd = (cyl < NUDGE_CYL_LIMIT) ? cmd + 16'd1 : cmd - 16'd1;
                    end
                    if (seek_cnt > cfg.seek_retry_limit || seek_cnt == SEEKS_FULL) begin
                        active = 1'b0;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_SEEK_FAIL;
                    end else begin
                        seek_cnt = seek_cnt + 5'd1;
                        res.kind = KIND_SEEK;
                        res.command_word = cmd;
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        item_t   it;
        result_t got;
        result_t want;
        if (!aresetn) begin
            cfg.bad_header_limit = BAD_LIMIT_RST;
            cfg.seek_retry_limit = RETRY_LIMIT_RST;
            active = 1'b0;
            goal_hd = 1'b0;
            goal_cyl = '0;
            skip = 1'b0;
            known_hd = 1'b0;
            known_cyl = '0;
            seek_cnt = '0;
            bad_cnt = '0;
            last_cyl = '0;
            last_hd = 1'b0;
            last_ok = 1'b0;
            outcome_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_IDX_BAD_LIMIT) begin
                    cfg.bad_header_limit = pwdata[5:0];
                end else begin
                    cfg.seek_retry_limit = pwdata[4:0];
                end
            end
            // take the result before the new transfer: it can only belong to older items
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser);
                got.command_word = m_tdata[15:0];
                got.sector = m_tdata[21:16];
                got.error_code = err_t'(m_tdata[23:22]);
                if (outcome_q.size() == 0) begin
                    $error("unexpected result transfer: kind %0d", got.kind);
                    fail_count = fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.kind != want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_count = fail_count + 1;
                    end
                    if (got.command_word != want.command_word) begin
                        $error("command_word: expected %h, got %h",
                               want.command_word, got.command_word);
                        fail_count = fail_count + 1;
                    end
                    if (got.sector != want.sector) begin
                        $error("sector: expected %0d, got %0d", want.sector, got.sector);
                        fail_count = fail_count + 1;
                    end
                    if (got.error_code != want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, got.error_code);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                it.op = op_t'(s_tuser);
                it.head = s_tdata[1:0];
                it.track = s_tdata[11:2];
                it.header_word = s_tdata[27:12];
                it.reserved_word = s_tdata[43:28];
                it.crc_word = s_tdata[59:44];
                advance_seek(it, want);
                outcome_q.push_back(want);
            end
        end
        pending = outcome_q.size();
    end

endmodule

FILE: tb/disk_header_seek_controller_test.sv
`timescale 1ns / 100ps
// Top of the disk header seek controller testbench: clock, reset, APB writes and
// request/header stimulus with random idling; the checker module does all comparing.
// Depends on dhsc_pkg, the controller RTL and disk_header_seek_controller_check.
module disk_header_seek_controller_test;
    import dhsc_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;
    logic                  s_tvalid;
    wire                   s_tready;
    // head[1:0], track[11:2], header_word[27:12], reserved_word[43:28], crc_word[59:44]
    logic [S_TDATA_W-1:0]  s_tdata;
    // op[0]
    logic                  s_tuser;
    wire                   m_tvalid;
    logic                  m_tready;
    // command_word[15:0], sector[21:16], error_code[23:22]
    wire  [M_TDATA_W-1:0]  m_tdata;
    // kind[1:0]
    wire  [1:0]            m_tuser;

    int fail_count;
    int pending;

    int send_idle_pct = 37;
    int recv_idle_pct = 88;
    int hold_cycles = 0;
    int items_sent = 0;
    int quota;
    logic [1:0] prev_goal_hd = 2'd0;
    logic [9:0] prev_goal_trk = 10'd0;
    logic [5:0] bad_lim;
    logic [4:0] retry_lim;

    disk_header_seek_controller uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    disk_header_seek_controller_check seek_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(64'd10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [15:0] frame_crc(input logic [31:0] msg);
        logic [15:0] crc;
        crc = '0;
        for (int b = 0; b < 32; b++) begin
            crc = (crc[0] ^ msg[b]) ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic item_t make_request(input logic [1:0] hd, input logic [9:0] trk);
        item_t it;
        it.op = OP_REQUEST;
        it.head = hd;
        it.track = trk;
        it.header_word = 16'($urandom);
        it.reserved_word = 16'($urandom);
        it.crc_word = 16'($urandom);
        return it;
    endfunction

    function automatic item_t make_header(input logic [8:0] cyl, input logic hb,
                                          input logic [5:0] sec, input bit good);
        item_t it;
        it.op = OP_HEADER;
        it.head = 2'($urandom_range(3));
        it.track = 10'($urandom_range(1023));
        it.header_word = {cyl, hb, sec};
        it.reserved_word = 16'($urandom);
        it.crc_word = frame_crc({it.reserved_word, it.header_word});
        if (!good) begin
            it.crc_word = it.crc_word ^ 16'($urandom_range(65535, 1));
        end
        return it;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.op = op_t'($urandom_range(1));
        it.head = 2'($urandom_range(3));
        it.track = 10'($urandom_range(1023));
        it.header_word = 16'($urandom);
        it.reserved_word = 16'($urandom);
        it.crc_word = 16'($urandom);
        return it;
    endfunction

    // favor the edges and the nudge boundary around cylinder 255
    function automatic logic [8:0] pick_cyl();
        case ($urandom_range(9))
            0: return 9'd0;
            1: return 9'd511;
            2: return NUDGE_CYL_LIMIT - 9'd2 + 9'($urandom_range(4));
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, it.crc_word, it.reserved_word, it.header_word, it.track, it.head};
        s_tuser <= it.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent = items_sent + 1;
        @(negedge aclk);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    // one request and the headers that follow it
    task automatic seek_session();
        logic [1:0] hd;
        logic [9:0] trk;
        logic [8:0] cyl;
        logic       hb;
        logic [8:0] prev_cyl;
        logic       prev_hb;
        bit         have_prev;
        bit         long_run;
        bit         all_bad;
        int         count;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            hd = 2'($urandom_range(3));
            trk = 10'($urandom_range(1023));
            if (pick < 4) begin
                hd[1] = 1'b1;
            end else begin
                trk[9] = 1'b1;
            end
            send_item(make_request(hd, trk));
            send_item(make_header(pick_cyl(), 1'($urandom_range(1)),
                                  6'($urandom_range(63)), 1'b1));
            return;
        end
        if (pick < 20) begin
            hd = prev_goal_hd;
            trk = prev_goal_trk;
        end else begin
            hd = 2'($urandom_range(1));
            case ($urandom_range(3))
                0: trk = 10'd0;
                1: trk = 10'd511;
                default: trk = 10'($urandom_range(511));
            endcase
        end
        prev_goal_hd = hd;
        prev_goal_trk = trk;
        send_item(make_request(hd, trk));
        long_run = ($urandom_range(99) < 6);
        all_bad = long_run && ($urandom_range(1) == 1);
        count = long_run ? 70 : $urandom_range(20, 1);
        have_prev = 1'b0;
        prev_cyl = '0;
        prev_hb = 1'b0;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (!long_run && pick < 4) begin
                send_item(noise_item());
                continue;
            end
            if (all_bad || (!long_run && pick < 18)) begin
                send_item(make_header(pick_cyl(), 1'($urandom_range(1)),
                                      6'($urandom_range(63)), 1'b0));
                continue;
            end
            if (!long_run && pick < 33) begin
                send_item(make_header(trk[8:0], hd[0], 6'($urandom_range(63)), 1'b1));
                break;
            end
            // repeat the last header often so the stuck-drive nudge gets exercised
            if (have_prev && pick >= 60) begin
                cyl = prev_cyl;
                hb = prev_hb;
            end else begin
                cyl = pick_cyl();
                hb = ($urandom_range(4) == 0) ? ~hd[0] : hd[0];
            end
            if (cyl == trk[8:0] && hb == hd[0]) begin
                hb = ~hb;
            end
            send_item(make_header(cyl, hb, 6'($urandom_range(63)), 1'b1));
            prev_cyl = cyl;
            prev_hb = hb;
            have_prev = 1'b1;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, reset limits
        send_item(make_header(9'd5, 1'b0, 6'd9, 1'b1));
        send_item(make_request(2'd2, 10'd5));
        send_item(make_request(2'd3, 10'd1023));
        send_item(make_request(2'd0, 10'd512));
        send_item(make_request(2'd1, 10'd511));
        send_item(make_header(9'd511, 1'b1, 6'd63, 1'b0));
        send_item(make_header(9'd0, 1'b0, 6'd0, 1'b1));
        send_item(make_header(9'd511, 1'b0, 6'd63, 1'b1));
        send_item(make_header(9'd511, 1'b1, 6'd63, 1'b1));
        send_item(make_request(2'd1, 10'd511));
        send_item(make_header(9'd0, 1'b0, 6'd17, 1'b1));
        send_item(make_request(2'd0, 10'd100));
        repeat (4) send_item(make_header(9'd300, 1'b0, 6'($urandom_range(63)), 1'b1));
        send_item(make_request(2'd0, 10'd100));
        repeat (4) send_item(make_header(9'd10, 1'b0, 6'($urandom_range(63)), 1'b1));

        for (int phase = 0; phase < 8; phase++) begin
            // drop valid so the last item is not taken again while draining
            s_tvalid <= 1'b0;
            while (pending != 0) @(negedge aclk);
            if (phase < 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 88;
            end else if (phase < 6) begin
                send_idle_pct = 88;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: begin bad_lim = 6'd0;  retry_lim = 5'd0;  end
                1: begin bad_lim = 6'd63; retry_lim = 5'd31; end
                3: begin bad_lim = 6'd1;  retry_lim = 5'd1;  end
                5: begin bad_lim = 6'd63; retry_lim = 5'd0;  end
                6: begin bad_lim = 6'd0;  retry_lim = 5'd31; end
                7: begin bad_lim = BAD_LIMIT_RST; retry_lim = RETRY_LIMIT_RST; end
                default: begin
                    bad_lim = 6'($urandom_range(63));
                    retry_lim = 5'($urandom_range(31));
                end
            endcase
            reg_write(REG_IDX_BAD_LIMIT, {26'd0, bad_lim});
            reg_write(REG_IDX_RETRY_LIMIT, {27'd0, retry_lim});
            if (phase == 6) begin
                hold_cycles = 300;
            end
            quota = items_sent + 50;
            while (items_sent < quota) seek_session();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dhsc_pkg.sv
rtl/core/dhsc_cfg.sv
rtl/core/dhsc_crc.sv
rtl/core/dhsc_core.sv
rtl/core/disk_header_seek_controller.sv
tb/disk_header_seek_controller_check.sv
tb/disk_header_seek_controller_test.sv
